@@ rtl/wfba_pkg.sv @@
// Shared types and codes for the worst-fit block allocator.
package wfba_pkg;

	typedef enum logic [1:0] {
		ST_LOADED  = 2'd0,
		ST_GRANTED = 2'd1,
		ST_NOFIT   = 2'd2
	} status_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_ALLOC = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_SORT,
		FS_SCAN,
		FS_MOVE,
		FS_DONE
	} fsm_t;

	localparam int CountBits = 4;

endpackage

@@ rtl/wfba_core.sv @@
// Sequencer that sorts, scans and reinserts blocks held in a size memory.
module wfba_core #(
	parameter int NUM_BLOCKS      = 8,
	parameter int SLOTS_PER_BLOCK = 5,
	parameter int SIZE_BITS       = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              is_load,
	input  logic [$clog2(NUM_BLOCKS+1)-1:0]  index_in,
	input  logic [7:0]                        label_in,
	input  logic [SIZE_BITS-1:0]              size_in,
	input  logic [wfba_pkg::CountBits-1:0]    count_cfg,
	input  logic                              cfg_we,
	output logic                              done,
	output wfba_pkg::status_t                 status_o,
	output logic [7:0]                        label_o,
	output logic [2:0]                        slot_o,
	output logic [SIZE_BITS-1:0]              remain_o
);
	import wfba_pkg::*;

	localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int PW = $clog2(NUM_BLOCKS + 1);
	localparam logic [SLOTS_PER_BLOCK-1:0] FULL = '1;

	// Size and label memories with registered reads: data follows the address in the next cycle.
	logic [SIZE_BITS-1:0] size_mem [NUM_BLOCKS];
	logic [7:0]           name_mem [NUM_BLOCKS];
	logic [SLOTS_PER_BLOCK-1:0] used_q [NUM_BLOCKS];
	logic [IW-1:0]        order_q [NUM_BLOCKS];
	logic                 sorted_q;

	fsm_t state_q, state_d;
	logic [PW-1:0] n_q, i_q, j_q, p_q;
	logic [SIZE_BITS-1:0] req_q, key_q;
	logic [IW-1:0] blk_q;
	logic [2:0] slot_q;
	logic [1:0] ph_q;   // 0/2 issue read, 1/3 data valid; 2 and 3 are used by sort only
	logic [SIZE_BITS-1:0] rd_size_q;
	logic [7:0] rd_name_q;
	logic [IW-1:0] rd_addr;
	logic wr_en;
	logic [IW-1:0] wr_addr;
	logic [SIZE_BITS-1:0] wr_data;
	status_t st_q;
	logic [PW-1:0] n_eff;
	logic [2:0] free_slot;
	logic [$clog2(SLOTS_PER_BLOCK+1)-1:0] free_ix;

	always_comb begin
		n_eff = PW'(count_cfg);
		if (count_cfg == '0) n_eff = PW'(1);
		if ({1'b0, count_cfg} > (CountBits+1)'(NUM_BLOCKS)) n_eff = PW'(NUM_BLOCKS);
	end

	always_comb begin
		free_ix = '0;
		for (int s = SLOTS_PER_BLOCK - 1; s >= 0; s--)
			if (!used_q[blk_q][s]) free_ix = ($bits(free_ix))'(s);
		free_slot = 3'(free_ix);
	end

	always_ff @(posedge clk) begin
		if (wr_en) size_mem[wr_addr] <= wr_data;
		if (start && is_load && index_in < PW'(NUM_BLOCKS))
			name_mem[index_in[IW-1:0]] <= label_in;
		rd_size_q <= size_mem[rd_addr];
		rd_name_q <= name_mem[rd_addr];
	end

	// Read address: sort reads order[i] then order[j], scan reads order[p], move reads order[p+1].
	always_comb begin
		rd_addr = order_q[p_q[IW-1:0]];
		if (state_q == FS_SORT) rd_addr = order_q[(ph_q == 2'd0) ? i_q[IW-1:0] : j_q[IW-1:0]];
		if (state_q == FS_MOVE) rd_addr = order_q[p_q[IW-1:0] + IW'(1)];
	end

	always_comb begin
		wr_en   = start && is_load && index_in < PW'(NUM_BLOCKS);
		wr_addr = index_in[IW-1:0];
		wr_data = size_in;
		if (state_q == FS_SCAN && ph_q == 2'd1 && rd_size_q >= req_q && used_q[blk_q] != FULL) begin
			wr_en   = 1'b1;
			wr_addr = blk_q;
			wr_data = rd_size_q - req_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_IDLE: if (start) state_d = is_load ? FS_DONE : (sorted_q ? FS_SCAN : FS_SORT);
			FS_SORT: if (i_q >= n_q) state_d = FS_SCAN;
			FS_SCAN: if (ph_q == 2'd1 && (p_q >= n_q ||
				(rd_size_q >= req_q && used_q[blk_q] != FULL))) state_d =
				(p_q >= n_q) ? FS_DONE : FS_MOVE;
				else if (p_q >= n_q) state_d = FS_DONE;
			FS_MOVE: if (p_q + PW'(1) >= n_q || (ph_q == 2'd1 && !(rd_size_q > key_q)))
				state_d = FS_DONE;
			FS_DONE: state_d = FS_IDLE;
			default: state_d = FS_IDLE;
		endcase
	end

	always_comb begin
		done = state_q == FS_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FS_IDLE;
			sorted_q <= 1'b0;
			ph_q     <= '0;
			for (int k = 0; k < NUM_BLOCKS; k++) begin
				order_q[k] <= IW'(k);
				used_q[k]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we || (start && is_load)) begin
				sorted_q <= 1'b0;
				for (int k = 0; k < NUM_BLOCKS; k++) order_q[k] <= IW'(k);
			end
			if (start && is_load && index_in < PW'(NUM_BLOCKS))
				used_q[index_in[IW-1:0]] <= '0;
			case (state_q)
				FS_IDLE: begin
					ph_q <= '0;
					if (start && !is_load) begin
						n_q <= n_eff; req_q <= size_in; p_q <= '0;
						i_q <= PW'(1); j_q <= PW'(1);
					end
				end
				FS_SORT: begin
					// Insertion sort: key holds size of order[j]; compare with order[j-1].
					if (i_q < n_q) begin
						if (ph_q == 2'd0) ph_q <= 2'd1;
						else if (ph_q == 2'd1) begin
							key_q <= rd_size_q; j_q <= j_q - PW'(1); ph_q <= 2'd2;
						end else if (ph_q == 2'd2) ph_q <= 2'd3;
						else begin
							if (key_q > rd_size_q) begin
								order_q[j_q[IW-1:0]] <= order_q[j_q[IW-1:0] + IW'(1)];
								order_q[j_q[IW-1:0] + IW'(1)] <= order_q[j_q[IW-1:0]];
							end
							if (key_q > rd_size_q && j_q != '0) begin
								j_q <= j_q - PW'(1); ph_q <= 2'd2;
							end else begin
								i_q <= i_q + PW'(1); j_q <= i_q + PW'(1); ph_q <= 2'd0;
							end
						end
					end else begin
						sorted_q <= 1'b1; ph_q <= '0;
					end
				end
				FS_SCAN: begin
					if (p_q >= n_q) begin
						st_q <= ST_NOFIT;
					end else if (ph_q == 2'd0) begin
						ph_q <= 2'd1; blk_q <= order_q[p_q[IW-1:0]];
					end else if (rd_size_q >= req_q && used_q[blk_q] != FULL) begin
						used_q[blk_q][free_ix] <= 1'b1;
						slot_q <= free_slot; key_q <= rd_size_q - req_q;
						label_o <= rd_name_q; st_q <= ST_GRANTED; ph_q <= '0;
					end else begin
						p_q <= p_q + PW'(1); ph_q <= 2'd0;
					end
				end
				FS_MOVE: begin
					if (ph_q == 2'd0) ph_q <= 2'd1;
					else begin
						ph_q <= 2'd0;
						if (rd_size_q > key_q && p_q + PW'(1) < n_q) begin
							order_q[p_q[IW-1:0]] <= order_q[p_q[IW-1:0] + IW'(1)];
							order_q[p_q[IW-1:0] + IW'(1)] <= order_q[p_q[IW-1:0]];
							p_q <= p_q + PW'(1);
						end
					end
				end
				FS_DONE: ;
				default: ;
			endcase
			if (state_q == FS_IDLE && start && is_load) st_q <= ST_LOADED;
		end
	end

	always_comb begin
		status_o = st_q;
		slot_o   = (st_q == ST_GRANTED) ? slot_q : 3'd0;
		remain_o = (st_q == ST_GRANTED) ? key_q : '0;
	end

endmodule

@@ rtl/worst_fit_block_allocator.sv @@
// Top level of the worst-fit block allocator: stream ports and result register.
//  channel | direction | content
//  s_axis  | in        | tdata: operation, block_index, block_label, capacity, request_size
//  m_axis  | out       | tdata: status, chosen_label, chosen_slot, remaining_size
//  cfg     | in        | block_count write
// An allocation reads each list position scanned, each position a block moves back plus the
// compare that stops it, and, on the first allocation after a load or count write, each sort
// comparison plus a fetch of each new key; the single read port of the size memory sets the
// pace. Reset clears the slot masks, restores the identity list order and sets the count to 8.
// A waiting result holds the input side until it is taken.
module worst_fit_block_allocator #(
	parameter int NUM_BLOCKS      = 8,
	parameter int SLOTS_PER_BLOCK = 5,
	parameter int SIZE_BITS       = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // operation, block_index, block_label, capacity, request_size
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // status, chosen_label, chosen_slot, remaining_size
	input  logic        cfg_we,
	input  logic [wfba_pkg::CountBits-1:0] cfg_wdata
);
	import wfba_pkg::*;

	localparam int PW = $clog2(NUM_BLOCKS + 1);

	logic [CountBits-1:0] count_q;
	logic busy_q, start, done, is_load;
	logic [PW-1:0] idx;
	logic [SIZE_BITS-1:0] size_sel;
	status_t st;
	logic [7:0] lbl;
	logic [2:0] slot;
	logic [SIZE_BITS-1:0] rem;
	logic [31:0] out_q;
	logic ovalid_q;

	assign s_axis_tready = !busy_q && !ovalid_q;
	assign start   = s_axis_tvalid && s_axis_tready;
	assign is_load = s_axis_tdata[0] == OP_LOAD;
	assign idx     = PW'(s_axis_tdata[3:1]);
	assign size_sel = is_load ? SIZE_BITS'(s_axis_tdata[27:12]) : SIZE_BITS'(s_axis_tdata[43:28]);

	wfba_core #(
		.NUM_BLOCKS(NUM_BLOCKS), .SLOTS_PER_BLOCK(SLOTS_PER_BLOCK), .SIZE_BITS(SIZE_BITS)
	) u_core (
		.clk(clk), .arst_n(arst_n), .start(start), .is_load(is_load), .index_in(idx),
		.label_in(s_axis_tdata[11:4]), .size_in(size_sel), .count_cfg(count_q),
		.cfg_we(cfg_we), .done(done), .status_o(st), .label_o(lbl), .slot_o(slot),
		.remain_o(rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= CountBits'(8);
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) count_q <= cfg_wdata;
			if (start) busy_q <= 1'b1;
			if (done) begin
				busy_q <= 1'b0; ovalid_q <= 1'b1;
			end else if (m_axis_tready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done)
			out_q <= {3'b0, 16'(rem), slot, (st == ST_GRANTED) ? lbl : 8'd0, st};
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = out_q;

endmodule

@@ dv/tb_worst_fit_block_allocator.sv @@
// Testbench for the worst-fit block allocator: stream stimulus, prediction and result checks.
module tb_worst_fit_block_allocator;
	import wfba_pkg::*;

	localparam int NBLK  = 8;
	localparam int NSLOT = 5;

	typedef struct packed {
		status_t     status;
		logic [7:0]  label;
		logic [2:0]  slot;
		logic [15:0] remaining;
	} grant_t;

	// Tracks the block list and predicts the result word for every accepted item.
	class alloc_scoreboard;
		logic [15:0] size_of [NBLK];
		logic [7:0]  name_of [NBLK];
		logic [4:0]  used [NBLK];
		logic [2:0]  order [NBLK];
		logic        sorted;
		logic [3:0]  count;
		grant_t      pending [$];
		int          errors;

		function new();
			count  = 4'd8;
			errors = 0;
			for (int i = 0; i < NBLK; i++) begin
				size_of[i] = '0;
				name_of[i] = '0;
				used[i]    = '0;
			end
			to_identity();
		endfunction

		function void to_identity();
			for (int i = 0; i < NBLK; i++) order[i] = i[2:0];
			sorted = 1'b0;
		endfunction

		function void set_count(logic [3:0] v);
			count = v;
			to_identity();
		endfunction

		function void note_item(logic [47:0] d);
			grant_t g;
			int n;
			int p;
			int s;
			logic [2:0] b;
			logic [2:0] t;
			logic [15:0] req;
			g = '{ST_NOFIT, 8'd0, 3'd0, 16'd0};
			if (op_t'(d[0]) == OP_LOAD) begin
				name_of[d[3:1]] = d[11:4];
				size_of[d[3:1]] = d[27:12];
				used[d[3:1]]    = '0;
				to_identity();
				g.status = ST_LOADED;
				pending.push_back(g);
				return;
			end
			n = (count < 4'd1) ? 1 : (count > 4'(NBLK)) ? NBLK : int'(count);
			if (!sorted) begin
				// Stable insertion sort, largest first.
				for (int i = 1; i < n; i++)
					for (int j = i; j > 0; j--) begin
						if (size_of[order[j]] > size_of[order[j-1]]) begin
							t = order[j]; order[j] = order[j-1]; order[j-1] = t;
						end else break;
					end
				sorted = 1'b1;
			end
			req = d[43:28];
			for (p = 0; p < n; p++) begin
				b = order[p];
				if (size_of[b] >= req && used[b] != 5'h1f) begin
					for (s = 0; s < NSLOT; s++) if (!used[b][s]) break;
					used[b][s] = 1'b1;
					size_of[b] = size_of[b] - req;
					while (p + 1 < n && size_of[order[p+1]] > size_of[b]) begin
						t = order[p+1]; order[p+1] = order[p]; order[p] = t;
						p++;
					end
					g = '{ST_GRANTED, name_of[b], s[2:0], size_of[b]};
					break;
				end
			end
			pending.push_back(g);
		endfunction

		function void check_word(logic [31:0] w);
			grant_t e;
			if (pending.size() == 0) begin
				$error("unexpected result word %h", w);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (w[1:0] !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, w[1:0]); errors++;
			end
			if (w[9:2] !== e.label) begin
				$error("chosen_label: expected %0d, got %0d", e.label, w[9:2]); errors++;
			end
			if (w[12:10] !== e.slot) begin
				$error("chosen_slot: expected %0d, got %0d", e.slot, w[12:10]); errors++;
			end
			if (w[28:13] !== e.remaining) begin
				$error("remaining_size: expected %0d, got %0d", e.remaining, w[28:13]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic [CountBits-1:0] cfg_wdata = '0;

	alloc_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;

	worst_fit_block_allocator dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: random stalls plus an optional long hold-off.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);

	task automatic send_word(logic [47:0] d);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = d;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(d);
	endtask

	task automatic load_block(logic [2:0] idx, logic [7:0] label, logic [15:0] cap);
		send_word({4'd0, 16'd0, cap, label, idx, OP_LOAD});
	endtask

	task automatic alloc_req(logic [15:0] req);
		send_word({4'd0, req, 16'd0, 8'd0, 3'd0, OP_ALLOC});
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_count(logic [3:0] v);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_count(v);
	endtask

	function automatic logic [15:0] rand_size();
		case ($urandom_range(0, 7))
			0: return 16'hffff;
			1, 2: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(0, 4000));
		endcase
	endfunction

	initial begin
		logic [3:0] counts [9] = '{4'd8, 4'd1, 4'd4, 4'd8, 4'd2, 4'd6, 4'd3, 4'd7, 4'd5};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, exact fit, slot exhaustion, no fit.
		send_idle_pct = 9;
		recv_idle_pct = 66;
		for (int i = 0; i < NBLK; i++)
			load_block(i[2:0], (i == 0) ? 8'hff : i[7:0], (i == 0) ? 16'hffff :
				(i == 7) ? 16'd0 : 16'(100 * i));
		alloc_req(16'hffff);
		alloc_req(16'd1);
		for (int k = 0; k < 6; k++) alloc_req(16'd10);
		alloc_req(16'd300);
		alloc_req(16'd60000);
		load_block(3'd7, 8'd0, 16'd50);
		alloc_req(16'd50);
		alloc_req(16'd1);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			send_idle_pct = (ph < 3) ? 9 : (ph < 6) ? 66 : 0;
			recv_idle_pct = (ph < 3) ? 66 : (ph < 6) ? 9 : 0;
			write_count(counts[ph]);
			for (int i = 0; i < NBLK; i++)
				load_block(i[2:0], 8'($urandom_range(0, 255)), rand_size());
			if (ph == 7) hold_cycles = 400;
			for (int k = 0; k < 200; k++) begin
				if ($urandom_range(0, 99) < 15)
					load_block(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
						rand_size());
				else if ($urandom_range(0, 9) == 0)
					alloc_req(16'($urandom_range(1, 65535)));
				else
					alloc_req(16'($urandom_range(1, 1500)));
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#40000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
